FILE: rtl/signed_integer_to_radix_symbols_macros.svh
// Assertion shorthands; every property is clocked on clk and held off during reset.
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH

// Same-cycle implication.
`define SIRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sirs_pkg.sv
package sirs_pkg;

  localparam int VALUE_W  = 32;
  localparam int SYM_W    = 8;
  localparam int NUM_SYMS = 16;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int MAX_DIGITS = 32;
  localparam int DPTR_W   = 5;
  localparam int BITCNT_W = 5;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

  // Register index, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_RADIX   = 2'd0,
    REG_SYM_LO  = 2'd1,
    REG_SYM_HI  = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  typedef logic [NUM_SYMS-1:0][SYM_W-1:0] sym_tbl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic digit_end;
    logic emit_sign;
    logic emit_digit;
  } sirs_cmd_t;

  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic idx_zero;
    logic out_free;
  } sirs_sts_t;

endpackage

FILE: rtl/sirs_ifs.sv
interface sirs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sirs_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirs_out_if;
  logic                        valid;
  logic                        ready;
  logic [sirs_pkg::SYM_W-1:0]  symbol;
  logic                        last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

FILE: rtl/signed_integer_to_radix_symbols.sv
// Channel   Direction  Payload                   Handshake
// in_ch     sink       value (s32)               valid / ready
// out_ch    source     symbol (8), last (1)      valid / ready
// cfg_*     slave      radix, symbols lo/hi      APB write/read, pready tied high
//
// Each digit comes from a bit-serial restoring divider that runs over the whole
// 32-bit magnitude; a minus sign, if any, is sent ahead of the digits.
// Synchronous active-low reset; registers return to radix 10 and empty alphabet.
// One request is in flight at a time; out_ch stalls hold the emitter.
`include "signed_integer_to_radix_symbols_macros.svh"

module signed_integer_to_radix_symbols #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sirs_in_if.sink                       in_ch,
  sirs_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sirs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sirs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [sirs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import sirs_pkg::*;

  logic [RADIX_W-1:0] radix;
  sym_tbl_t           sym_tbl;
  logic               alpha_ok;
  sirs_cmd_t          cmd;
  sirs_sts_t          sts;

  assign cfg_pready = 1'b1;

  sirs_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .radix    (radix),
    .sym_tbl  (sym_tbl),
    .alpha_ok (alpha_ok)
  );

  sirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .alpha_ok (alpha_ok),
    .sts      (sts),
    .cmd      (cmd)
  );

  sirs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_ch.value),
    .radix      (radix),
    .sym_tbl    (sym_tbl),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_symbol (out_ch.symbol),
    .out_last   (out_ch.last)
  );

  `SIRS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted request left block ready")
  `SIRS_ASSERT_NOW(a_minus_not_last, out_ch.valid && out_ch.symbol == SYM_MINUS, !out_ch.last, "minus sign flagged as last")
  `SIRS_ASSERT_NOW(a_no_zero_symbol, out_ch.valid, out_ch.symbol != '0, "zero symbol emitted")

endmodule

FILE: rtl/sirs_cfg.sv
module sirs_cfg #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sirs_pkg::CFG_AW-1:0]    paddr,
  input  logic [sirs_pkg::CFG_DW-1:0]    pwdata,
  output logic [sirs_pkg::CFG_DW-1:0]    prdata,
  output logic [sirs_pkg::RADIX_W-1:0]   radix,
  output sirs_pkg::sym_tbl_t             sym_tbl,
  output logic                           alpha_ok
);
  import sirs_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [CFG_DW-1:0]  sym_lo_r;
  logic [CFG_DW-1:0]  sym_hi_r;
  logic               alpha_ok_r;
  logic               alpha_ok_nxt;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RESET;
      sym_lo_r   <= '0;
      sym_hi_r   <= '0;
      alpha_ok_r <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_nxt;
      if (wr_en) begin
        case (idx)
          REG_RADIX:  radix_r  <= pwdata[RADIX_W-1:0];
          REG_SYM_LO: sym_lo_r <= pwdata;
          REG_SYM_HI: sym_hi_r <= pwdata;
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_RADIX:  prdata = {{(CFG_DW-RADIX_W){1'b0}}, radix_r};
      REG_SYM_LO: prdata = sym_lo_r;
      REG_SYM_HI: prdata = sym_hi_r;
      default:    prdata = '0;
    endcase
  end

  assign sym_tbl = {sym_hi_r, sym_lo_r};

  // Reject short or oversized alphabets, sign or zero symbols, and duplicates in use.
  always_comb begin
    alpha_ok_nxt = 1'b1;
    if (radix_r < RADIX_MIN || radix_r > RADIX_W'(MAX_SYMBOLS)) begin
      alpha_ok_nxt = 1'b0;
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if (sym_tbl[i] == '0 || sym_tbl[i] == SYM_PLUS || sym_tbl[i] == SYM_MINUS) begin
          alpha_ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (RADIX_W'(j) < radix_r && sym_tbl[j] == sym_tbl[i]) begin
            alpha_ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign radix    = radix_r;
  assign alpha_ok = alpha_ok_r;

endmodule

FILE: rtl/sirs_dp.sv
module sirs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sirs_pkg::sirs_cmd_t                 cmd,
  output sirs_pkg::sirs_sts_t                 sts,
  input  logic signed [sirs_pkg::VALUE_W-1:0] in_value,
  input  logic [sirs_pkg::RADIX_W-1:0]        radix,
  input  sirs_pkg::sym_tbl_t                  sym_tbl,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sirs_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last
);
  import sirs_pkg::*;

  logic [VALUE_W-1:0] mag_r;
  logic [DIGIT_W-1:0] rem_r;
  logic               neg_r;
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];
  logic [DPTR_W-1:0]  wp_r;
  logic [DPTR_W-1:0]  rd_r;
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_symbol_r;
  logic               out_last_r;

  logic [VALUE_W-1:0] in_u;
  logic [RADIX_W-1:0] rem_s;
  logic               ge;
  logic [DIGIT_W-1:0] rem_step;
  logic [VALUE_W-1:0] quo_step;

  assign in_u = unsigned'(in_value);

  // One restoring-division bit per step.
  always_comb begin
    rem_s    = {rem_r, mag_r[VALUE_W-1]};
    ge       = (rem_s >= radix);
    rem_step = ge ? DIGIT_W'(rem_s - radix) : rem_s[DIGIT_W-1:0];
    quo_step = {mag_r[VALUE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_u[VALUE_W-1];
      mag_r <= in_u[VALUE_W-1] ? (~in_u + VALUE_W'(1)) : in_u;
      rem_r <= '0;
      wp_r  <= '0;
    end else if (cmd.step) begin
      mag_r <= quo_step;
      if (cmd.digit_end) begin
        digits_r[wp_r] <= rem_step;
        rd_r  <= wp_r;
        wp_r  <= wp_r + DPTR_W'(1);
        rem_r <= '0;
      end else begin
        rem_r <= rem_step;
      end
    end else if (cmd.emit_digit) begin
      rd_r <= rd_r - DPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_symbol_r <= SYM_MINUS;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_symbol_r <= sym_tbl[digits_r[rd_r]];
      out_last_r   <= (rd_r == '0);
    end
  end

  assign sts.neg       = neg_r;
  assign sts.quot_zero = (quo_step == '0);
  assign sts.idx_zero  = (rd_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

FILE: rtl/sirs_ctrl.sv
module sirs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                alpha_ok,
  input  sirs_pkg::sirs_sts_t sts,
  output sirs_pkg::sirs_cmd_t cmd
);
  import sirs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [BITCNT_W-1:0] bit_cnt_r;
  logic                last_bit;

  assign last_bit = (bit_cnt_r == BITCNT_W'(VALUE_W - 1));
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_DIV: begin
        cmd.step      = 1'b1;
        cmd.digit_end = last_bit;
      end
      ST_SIGN:  cmd.emit_sign  = sts.out_free;
      ST_EMIT:  cmd.emit_digit = sts.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          bit_cnt_r <= '0;
          state_r   <= alpha_ok ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          bit_cnt_r <= bit_cnt_r + BITCNT_W'(1);
          // Stop dividing once the quotient runs out.
          if (last_bit && sts.quot_zero) begin
            state_r <= sts.neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (sts.out_free) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts.out_free && sts.idx_zero) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
